@@ src/tlbmmu_pkg.sv @@
// ----------------------------------------------------------------------------
// tlbmmu_pkg
// Shared sizes, table entry layouts and register indexes of the TLB/paging MMU.
// ----------------------------------------------------------------------------
package tlbmmu_pkg;

  localparam int VIRT_PAGES  = 1024;
  localparam int FRAMES      = 64;
  localparam int TLB_ENTRIES = 16;

  localparam int VPN_W   = $clog2(VIRT_PAGES);
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int SLOT_W  = $clog2(TLB_ENTRIES);
  localparam int PN_W    = 11;
  localparam int FN_W    = 7;
  localparam int TN_W    = 5;
  localparam int SH_W    = 5;

  localparam logic [2:0] REG_TLB_LRU    = 3'd0;
  localparam logic [2:0] REG_PAGE_LRU   = 3'd1;
  localparam logic [2:0] REG_VIRT_PAGES = 3'd2;
  localparam logic [2:0] REG_FRAMES     = 3'd3;
  localparam logic [2:0] REG_TLB_SLOTS  = 3'd4;
  localparam logic [2:0] REG_PAGE_SHIFT = 3'd5;

  typedef struct packed {
    logic               resident;
    logic               written;
    logic [FRAME_W-1:0] frame;
  } pt_entry_t;

  typedef struct packed {
    logic [VPN_W-1:0] owner;
    logic [31:0]      stamp;
  } ft_entry_t;

  typedef struct packed {
    logic               init;
    logic               fill;
    logic               touch;
    logic [SLOT_W-1:0]  slot;
    logic [VPN_W-1:0]   vpn;
    logic [FRAME_W-1:0] frame;
  } tlb_cmd_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [FRAME_W-1:0] frame;
    logic [SLOT_W-1:0]  victim;
    logic               busy;
  } tlb_stat_t;

endpackage

@@ src/tlbmmu_ram.sv @@
// ----------------------------------------------------------------------------
// tlbmmu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tlbmmu_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/tlbmmu_tlb.sv @@
// ----------------------------------------------------------------------------
// tlbmmu_tlb
// Fully associative TLB: parallel lookup, slot refill, stamps and victim pick.
// ----------------------------------------------------------------------------
module tlbmmu_tlb (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 lru_mode,
  input  logic [tlbmmu_pkg::TN_W-1:0]  tn,
  input  logic [tlbmmu_pkg::VPN_W-1:0] lookup_vpn,
  input  tlbmmu_pkg::tlb_cmd_t cmd,
  output tlbmmu_pkg::tlb_stat_t stat
);
  import tlbmmu_pkg::*;

  logic [VPN_W-1:0]   vpage [TLB_ENTRIES];
  logic [FRAME_W-1:0] frame [TLB_ENTRIES];
  logic [31:0]        stamp [TLB_ENTRIES];
  logic [31:0]        clock;
  logic [SLOT_W-1:0]  victim;
  logic               busy;
  logic [TN_W-1:0]    scan_idx;
  logic [31:0]        best_stamp;
  logic [SLOT_W-1:0]  best_idx;
  logic               hit;
  logic [SLOT_W-1:0]  hit_slot;
  logic [TN_W-1:0]    slot_inc;

  // lowest matching slot among those in use
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = TLB_ENTRIES - 1; s >= 0; s--) begin
      if (TN_W'(s) < tn && vpage[s] == lookup_vpn) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(s);
      end
    end
  end

  assign slot_inc = TN_W'(cmd.slot) + TN_W'(1);

  always_comb begin
    stat.hit    = hit;
    stat.slot   = hit_slot;
    stat.frame  = frame[hit_slot];
    stat.victim = victim;
    stat.busy   = busy;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int s = 0; s < TLB_ENTRIES; s++) begin
        vpage[s] <= VPN_W'(s);
        frame[s] <= FRAME_W'(s);
        stamp[s] <= '0;
      end
      clock    <= '0;
      victim   <= '0;
      busy     <= 1'b0;
      scan_idx <= '0;
    end else begin
      if (cmd.fill) begin
        vpage[cmd.slot] <= cmd.vpn;
        frame[cmd.slot] <= cmd.frame;
      end
      if (cmd.touch) begin
        if (lru_mode) begin
          clock           <= clock + 32'd1;
          stamp[cmd.slot] <= clock + 32'd1;
          busy            <= 1'b1;
          scan_idx        <= '0;
        end else if (cmd.fill) begin
          victim <= (slot_inc < tn) ? slot_inc[SLOT_W-1:0] : '0;
        end
      end else if (busy) begin
        if (scan_idx < tn) begin
          if (scan_idx == '0 || stamp[scan_idx[SLOT_W-1:0]] < best_stamp) begin
            best_stamp <= stamp[scan_idx[SLOT_W-1:0]];
            best_idx   <= scan_idx[SLOT_W-1:0];
          end
          scan_idx <= scan_idx + TN_W'(1);
        end else begin
          victim <= best_idx;
          busy   <= 1'b0;
        end
      end
    end
  end

endmodule

@@ src/tlb_page_replacement_mmu.sv @@
// ----------------------------------------------------------------------------
// tlb_page_replacement_mmu
// Translating memory unit: TLB in front of a page table, demand paging.
// ----------------------------------------------------------------------------
// One access is in flight at a time. A bad address goes from the lookup straight
// to the result; a TLB hit adds a scan state, a miss on a resident page also a
// page table read, a page fault also the frame table read, the old page's entry
// and the new page's entry write. In TLB LRU mode each TLB hit or refill adds a
// TLB stamp scan over the slots in use; in page LRU mode a miss adds a scan over
// the frame table, one frame read per cycle from its single read port. The TLB
// scan runs alongside. After reset and after every register write a clearing
// pass rebuilds the page and frame tables; no access is taken meanwhile.
module tlb_page_replacement_mmu (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // address[31:0]
  input  logic [0:0]   s_tuser,   // kind[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // phys_address[31:0], tlb_miss_count[63:32], page_fault_count[95:64],
  // disk_write_count[127:96]
  output logic [127:0] m_tdata,
  // tlb_hit[0], page_fault[1], disk_write[2], bad_address[3]
  output logic [3:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import tlbmmu_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_PT_WAIT, ST_FT_WAIT, ST_OLD_WAIT,
    ST_NEW_WR, ST_SCAN, ST_DONE
  } state_t;

  state_t state;

  logic            tlb_lru, page_lru;
  logic [PN_W-1:0] virt_pages_used;
  logic [FN_W-1:0] frames_used;
  logic [TN_W-1:0] tlb_slots_used;
  logic [SH_W-1:0] page_shift;

  logic [PN_W-1:0] pn;
  logic [FN_W-1:0] fn, fn_hi;
  logic [TN_W-1:0] tn, tn_hi;

  logic               kind_q;
  logic [31:0]        addr_q;
  logic [VPN_W-1:0]   vpn_q;
  logic [VPN_W-1:0]   old_q;
  logic [SLOT_W-1:0]  pos_q;
  logic [FRAME_W-1:0] frame_q;
  logic               hit_q, fault_q, dw_q, bad_q, written_new;
  logic [FRAME_W-1:0] frame_victim;
  logic [31:0]        page_clock;
  logic [31:0]        tlb_misses, page_faults, disk_writes;
  logic [PN_W-1:0]    cnt;
  logic               need_fscan, cmp_v;
  logic [FRAME_W-1:0] cmp_idx, best_idx;
  logic [31:0]        best_stamp;

  logic      cfg_wr;
  logic [31:0] vpn_full;
  logic [FN_W-1:0] frame_inc;

  logic             pt_we;
  logic [VPN_W-1:0] pt_waddr, pt_raddr;
  pt_entry_t        pt_wdata, pt_rdata;
  logic               ft_we;
  logic [FRAME_W-1:0] ft_waddr, ft_raddr;
  ft_entry_t          ft_wdata, ft_rdata;

  tlb_cmd_t  tcmd;
  tlb_stat_t tstat;

  // effective counts
  always_comb begin
    pn    = (virt_pages_used == '0) ? PN_W'(1) :
            (virt_pages_used > PN_W'(VIRT_PAGES)) ? PN_W'(VIRT_PAGES) : virt_pages_used;
    fn_hi = (pn < PN_W'(FRAMES)) ? pn[FN_W-1:0] : FN_W'(FRAMES);
    fn    = (frames_used == '0) ? FN_W'(1) :
            (frames_used > fn_hi) ? fn_hi : frames_used;
    tn_hi = (fn < FN_W'(TLB_ENTRIES)) ? fn[TN_W-1:0] : TN_W'(TLB_ENTRIES);
    tn    = (tlb_slots_used == '0) ? TN_W'(1) :
            (tlb_slots_used > tn_hi) ? tn_hi : tlb_slots_used;
  end

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign s_tready = (state == ST_IDLE);
  assign vpn_full = addr_q >> page_shift;
  assign frame_inc = FN_W'(frame_q) + FN_W'(1);

  always_comb begin
    unique case (paddr[4:2])
      REG_TLB_LRU:    prdata = {31'd0, tlb_lru};
      REG_PAGE_LRU:   prdata = {31'd0, page_lru};
      REG_VIRT_PAGES: prdata = {21'd0, virt_pages_used};
      REG_FRAMES:     prdata = {25'd0, frames_used};
      REG_TLB_SLOTS:  prdata = {27'd0, tlb_slots_used};
      REG_PAGE_SHIFT: prdata = {27'd0, page_shift};
      default:        prdata = '0;
    endcase
  end

  // table port steering
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = vpn_q;
    pt_wdata = '0;
    pt_raddr = vpn_q;
    ft_we    = 1'b0;
    ft_waddr = frame_q;
    ft_wdata = '0;
    ft_raddr = frame_victim;
    tcmd       = '0;
    tcmd.slot  = pos_q;
    tcmd.vpn   = vpn_q;
    tcmd.frame = pt_rdata.resident ? pt_rdata.frame : frame_victim;
    tcmd.init  = cfg_wr && (paddr[4:2] <= REG_PAGE_SHIFT);
    case (state)
      ST_CLEAR: begin
        pt_we             = 1'b1;
        pt_waddr          = cnt[VPN_W-1:0];
        pt_wdata.resident = (cnt < PN_W'(fn));
        pt_wdata.frame    = (cnt < PN_W'(fn)) ? cnt[FRAME_W-1:0] : '0;
        ft_we             = (cnt < PN_W'(FRAMES));
        ft_waddr          = cnt[FRAME_W-1:0];
        ft_wdata.owner    = cnt[VPN_W-1:0];
      end
      ST_LOOK: begin
        // page table entry is read while the TLB is searched
        pt_raddr = vpn_full[VPN_W-1:0];
        if (vpn_full < 32'(pn) && tstat.hit) begin
          tcmd.touch = 1'b1;
          tcmd.slot  = tstat.slot;
        end
      end
      ST_PT_WAIT: begin
        tcmd.fill  = 1'b1;
        tcmd.touch = 1'b1;
        if (pt_rdata.resident && page_lru) begin
          ft_we          = 1'b1;
          ft_waddr       = pt_rdata.frame;
          ft_wdata.owner = vpn_q;
          ft_wdata.stamp = page_clock + 32'd1;
        end
      end
      ST_FT_WAIT: begin
        pt_raddr       = ft_rdata.owner;
        ft_we          = 1'b1;
        ft_wdata.owner = vpn_q;
        ft_wdata.stamp = page_lru ? page_clock + 32'd1 : '0;
      end
      ST_OLD_WAIT: begin
        pt_we            = 1'b1;
        pt_waddr         = old_q;
        pt_wdata.written = kind_q ? 1'b0 : pt_rdata.written;
      end
      ST_NEW_WR: begin
        pt_we             = 1'b1;
        pt_wdata.resident = 1'b1;
        pt_wdata.written  = written_new;
        pt_wdata.frame    = frame_q;
      end
      ST_SCAN: begin
        ft_raddr = cnt[FRAME_W-1:0];
      end
      default: begin
      end
    endcase
  end

  tlbmmu_ram #(.DEPTH(VIRT_PAGES), .WIDTH($bits(pt_entry_t))) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  tlbmmu_ram #(.DEPTH(FRAMES), .WIDTH($bits(ft_entry_t))) u_frame_table (
    .clk   (clk),
    .we    (ft_we),
    .waddr (ft_waddr),
    .wdata (ft_wdata),
    .raddr (ft_raddr),
    .rdata (ft_rdata)
  );

  tlbmmu_tlb u_tlb (
    .clk        (clk),
    .rst        (rst),
    .lru_mode   (tlb_lru),
    .tn         (tn),
    .lookup_vpn (vpn_full[VPN_W-1:0]),
    .cmd        (tcmd),
    .stat       (tstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      cnt             <= '0;
      tlb_lru         <= 1'b0;
      page_lru        <= 1'b0;
      virt_pages_used <= PN_W'(1024);
      frames_used     <= FN_W'(64);
      tlb_slots_used  <= TN_W'(16);
      page_shift      <= SH_W'(8);
      frame_victim    <= '0;
      page_clock      <= '0;
      tlb_misses      <= '0;
      page_faults     <= '0;
      disk_writes     <= '0;
      need_fscan      <= 1'b0;
      cmp_v           <= 1'b0;
      m_tvalid        <= 1'b0;
    end else if (cfg_wr && paddr[4:2] <= REG_PAGE_SHIFT) begin
      unique case (paddr[4:2])
        REG_TLB_LRU:    tlb_lru         <= pwdata[0];
        REG_PAGE_LRU:   page_lru        <= pwdata[0];
        REG_VIRT_PAGES: virt_pages_used <= pwdata[PN_W-1:0];
        REG_FRAMES:     frames_used     <= pwdata[FN_W-1:0];
        REG_TLB_SLOTS:  tlb_slots_used  <= pwdata[TN_W-1:0];
        default:        page_shift      <= pwdata[SH_W-1:0];
      endcase
      state        <= ST_CLEAR;
      cnt          <= '0;
      frame_victim <= '0;
      page_clock   <= '0;
      tlb_misses   <= '0;
      page_faults  <= '0;
      disk_writes  <= '0;
      need_fscan   <= 1'b0;
      cmp_v        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          cnt <= cnt + PN_W'(1);
          if (cnt == PN_W'(VIRT_PAGES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            kind_q  <= s_tuser[0];
            addr_q  <= s_tdata;
            hit_q   <= 1'b0;
            fault_q <= 1'b0;
            dw_q    <= 1'b0;
            bad_q   <= 1'b0;
            frame_q <= '0;
            state   <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          vpn_q <= vpn_full[VPN_W-1:0];
          pos_q <= tstat.victim;
          if (vpn_full >= 32'(pn)) begin
            bad_q <= 1'b1;
            state <= ST_DONE;
          end else if (tstat.hit) begin
            hit_q   <= 1'b1;
            frame_q <= tstat.frame;
            state   <= ST_SCAN;
          end else begin
            tlb_misses <= tlb_misses + 32'd1;
            state      <= ST_PT_WAIT;
          end
        end
        ST_PT_WAIT: begin
          if (pt_rdata.resident) begin
            frame_q <= pt_rdata.frame;
            if (page_lru) begin
              page_clock <= page_clock + 32'd1;
              need_fscan <= 1'b1;
              cnt        <= '0;
            end
            state <= ST_SCAN;
          end else begin
            fault_q     <= 1'b1;
            page_faults <= page_faults + 32'd1;
            dw_q        <= kind_q | pt_rdata.written;
            written_new <= kind_q | pt_rdata.written;
            if (kind_q || pt_rdata.written) begin
              disk_writes <= disk_writes + 32'd1;
            end
            frame_q <= frame_victim;
            state   <= ST_FT_WAIT;
          end
        end
        ST_FT_WAIT: begin
          old_q <= ft_rdata.owner;
          if (page_lru) begin
            page_clock <= page_clock + 32'd1;
          end
          state <= ST_OLD_WAIT;
        end
        ST_OLD_WAIT: begin
          state <= ST_NEW_WR;
        end
        ST_NEW_WR: begin
          if (page_lru) begin
            need_fscan <= 1'b1;
            cnt        <= '0;
          end else begin
            frame_victim <= (frame_inc < fn) ? frame_inc[FRAME_W-1:0] : '0;
          end
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          // each frame table read is compared in the cycle after it is issued
          if (need_fscan) begin
            cmp_v   <= (cnt < PN_W'(fn));
            cmp_idx <= cnt[FRAME_W-1:0];
            if (cnt < PN_W'(fn)) begin
              cnt <= cnt + PN_W'(1);
            end
            if (cmp_v && (cmp_idx == '0 || ft_rdata.stamp < best_stamp)) begin
              best_stamp <= ft_rdata.stamp;
              best_idx   <= cmp_idx;
            end
            if (cnt >= PN_W'(fn) && !cmp_v) begin
              frame_victim <= best_idx;
              need_fscan   <= 1'b0;
            end
          end else if (!tstat.busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid         <= 1'b1;
            m_tdata[31:0]    <= bad_q ? 32'd0 :
                                ((32'(frame_q) << page_shift) |
                                 (addr_q & ~(32'hFFFF_FFFF << page_shift)));
            m_tdata[63:32]   <= tlb_misses;
            m_tdata[95:64]   <= page_faults;
            m_tdata[127:96]  <= disk_writes;
            m_tuser          <= {bad_q, dw_q, fault_q, hit_q};
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/tlbmmu_checker.sv @@
// ----------------------------------------------------------------------------
// tlbmmu_checker
// Port-level checks on the result stream of the MMU.
// ----------------------------------------------------------------------------
module tlbmmu_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic [3:0]   m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an ignored access reports a zero address and no flag but its own
  a_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |-> m_tdata[31:0] == 32'd0 && m_tuser[2:0] == 3'd0)
    else $error("bad address with translation");

  a_dw: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1])
    else $error("disk write without page fault");

  a_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("tlb hit with page fault");

endmodule

bind tlb_page_replacement_mmu tlbmmu_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
